// ===== rtl/bru_pkg.sv =====
// Package for the bitmap row union accumulator.
// Holds sizes, the row tag type and the tag controller status struct.
// No dependencies.
package bru_pkg;

    localparam int NUM_COLS = 4096;
    localparam int COL_W    = 12;
    localparam int ADDR_W   = $clog2(NUM_COLS);
    localparam int TAG_W    = 16;

    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;

    // Tag zero is what the clearing pass writes, so live rows use 1 to TAG_MAX.
    localparam t_tag TAG_CLEAR = '0;
    localparam t_tag TAG_FIRST = t_tag'(1);
    localparam t_tag TAG_MAX   = '1;
    localparam t_addr ADDR_LAST = t_addr'(NUM_COLS - 1);

    typedef struct packed {
        logic  clearing;
        logic  wrap_next;
        t_tag  tag;
        t_addr clr_addr;
    } t_tag_status;

endpackage

// ===== rtl/bru_tag_ram.sv =====
// Simple dual port tag memory: one write port and one registered read port.
// Generic over depth and width; no package dependency.
module bru_tag_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bru_tag_ctrl.sv =====
// Row tag controller: holds the tag of the open row and runs the clearing pass.
// Depends on bru_pkg.
module bru_tag_ctrl
    import bru_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_row_close,
    output t_tag_status o_status
);

    logic  r_clearing, n_clearing;
    t_tag  r_tag, n_tag;
    t_addr r_clr_addr, n_clr_addr;

    always_comb begin
        n_clearing = r_clearing;
        n_tag      = r_tag;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + t_addr'(1);
            if (r_clr_addr == ADDR_LAST) begin
                n_clearing = 1'b0;
            end
        end else if (i_row_close) begin
            // Once the tags run out, old tags in memory could alias a new row,
            // so the whole memory is swept back to the clear tag.
            if (r_tag == TAG_MAX) begin
                n_clearing = 1'b1;
                n_clr_addr = '0;
                n_tag      = TAG_FIRST;
            end else begin
                n_tag = r_tag + t_tag'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_tag      <= TAG_FIRST;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_tag      <= n_tag;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign o_status.clearing  = r_clearing;
    assign o_status.wrap_next = (r_tag == TAG_MAX);
    assign o_status.tag       = r_tag;
    assign o_status.clr_addr  = r_clr_addr;

endmodule

// ===== rtl/bitmap_row_union_accumulator.sv =====
// Top level of the bitmap row union accumulator.
// Depends on bru_pkg, bru_tag_ram and bru_tag_ctrl.
//
//   Channel  Handshake          Fields
//   in       i_valid / o_stall  i_has_entry, i_col_index, i_row_last
//   out      o_valid / i_stall  o_col_out, o_fresh, o_row_done
//
// One item per cycle while o_stall is low: the tag memory is read at the edge that takes an
// item; the compare and write-back happen as it moves from the lookup stage to the output.
// Entries hold the tag of the row that last marked them, so a row close only moves the tag on.
// After reset, and again every 65535 closed rows, a clearing pass sweeps all NUM_COLS (4096)
// entries of the memory and no item is taken meanwhile. A stalled result holds the output
// register; one more item may then wait in the lookup stage before the input stalls.
module bitmap_row_union_accumulator
    import bru_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic i_has_entry,
    input  t_col i_col_index,
    input  logic i_row_last,
    output logic o_valid,
    input  logic i_stall,
    output t_col o_col_out,
    output logic o_fresh,
    output logic o_row_done
);

    t_tag_status st;

    logic  in_acc;
    logic  s1_adv;
    logic  in_range;
    logic  fw_hit;
    t_tag  rd_tag;
    t_tag  cur_tag;
    logic  s1_fresh;
    logic  ram_we;
    t_addr ram_waddr;
    t_tag  ram_wdata;

    // Lookup stage.
    logic  r_s1_valid;
    logic  r_s1_has_entry;
    logic  r_s1_in_range;
    t_col  r_s1_col;
    logic  r_s1_row_last;

    // Last write made by the lookup stage, for a following item at the same entry.
    logic  r_fw_valid;
    t_addr r_fw_addr;
    t_tag  r_fw_tag;

    logic  r_out_valid;
    t_col  r_out_col;
    logic  r_out_fresh;
    logic  r_out_row_done;

    bru_tag_ctrl u_tag_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_close (s1_adv && r_s1_row_last),
        .o_status    (st)
    );

    assign s1_adv = r_s1_valid && (!r_out_valid || !i_stall);
    // A row close that uses up the last tag starts a pass, so nothing may enter behind it.
    assign o_stall = st.clearing || (r_s1_valid && !s1_adv)
                     || (s1_adv && r_s1_row_last && st.wrap_next);
    assign in_acc  = i_valid && !o_stall;

    assign in_range = (32'(i_col_index) < 32'(NUM_COLS));

    assign fw_hit   = r_fw_valid && (r_fw_addr == t_addr'(r_s1_col));
    assign cur_tag  = fw_hit ? r_fw_tag : rd_tag;
    assign s1_fresh = r_s1_has_entry && r_s1_in_range && (cur_tag != st.tag);

    always_comb begin
        if (st.clearing) begin
            ram_we    = 1'b1;
            ram_waddr = st.clr_addr;
            ram_wdata = TAG_CLEAR;
        end else begin
            ram_we    = s1_adv && s1_fresh;
            ram_waddr = t_addr'(r_s1_col);
            ram_wdata = st.tag;
        end
    end

    bru_tag_ram #(
        .DEPTH (NUM_COLS),
        .WIDTH (TAG_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (t_addr'(i_col_index)),
        .o_rdata (rd_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (st.clearing) begin
                r_fw_valid <= 1'b0;
            end else if (s1_adv) begin
                r_fw_valid <= s1_fresh;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_has_entry <= i_has_entry;
            r_s1_in_range  <= in_range;
            r_s1_col       <= i_col_index;
            r_s1_row_last  <= i_row_last;
        end
        if (s1_adv) begin
            r_fw_addr      <= t_addr'(r_s1_col);
            r_fw_tag       <= st.tag;
            r_out_col      <= r_s1_has_entry ? r_s1_col : '0;
            r_out_fresh    <= s1_fresh;
            r_out_row_done <= r_s1_row_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_col_out  = r_out_col;
    assign o_fresh    = r_out_fresh;
    assign o_row_done = r_out_row_done;

endmodule

// ===== rtl/bru_checker.sv =====
// Port-level checker for the bitmap row union accumulator, bound to the top level.
// Depends on bru_pkg and bitmap_row_union_accumulator.
module bru_checker
    import bru_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_col o_col_out,
    input logic o_fresh,
    input logic o_row_done
);

    // The memory is swept after reset, so no item may be taken straight away.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result withdrawn");

    // Two results taken back to back within one row are never both fresh for the same column.
    a_no_double_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_fresh && !o_row_done)
        ##1 (o_valid && !i_stall && o_fresh)
        |-> (o_col_out != $past(o_col_out)))
        else $error("column reported fresh twice in one row");

    // A newly raised result must have a matching item taken at the input.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a matching item");

endmodule

bind bitmap_row_union_accumulator bru_checker u_bru_checker (.*);
